// ----- src/octc_pkg.sv -----
// Shared types, codes and helper functions for the oven cook-timer controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package octc_pkg;

  localparam int NUM_DIGITS    = 4;
  localparam int CNT_W         = $clog2(NUM_DIGITS + 1);
  localparam int SEC_W         = 13;
  localparam int ADD_W         = 12;
  localparam int ALM_W         = 4;
  localparam int QUEUE_DEPTH_D = 2;

  localparam logic [SEC_W-1:0] TEN   = SEC_W'(10);
  localparam logic [SEC_W-1:0] SIXTY = SEC_W'(60);

  localparam logic [ADD_W-1:0] ADD_STEP_RST = ADD_W'(30);
  localparam logic [SEC_W-1:0] MAX_SEC_RST  = SEC_W'(3599);
  localparam logic [ALM_W-1:0] ALARM_RST    = ALM_W'(5);
  localparam logic [ALM_W-1:0] ALARM_SAT    = ALM_W'(15);

  localparam logic [3:0] MAX_DIGIT = 4'd9;

  // input event codes
  localparam logic [2:0] MODE_DIGIT = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_ADD   = 3'd3;
  localparam logic [2:0] MODE_DOOR  = 3'd4;
  localparam logic [2:0] MODE_TICK  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_ADD_STEP = 2'd0;
  localparam logic [1:0] CFG_MAX_SEC  = 2'd1;
  localparam logic [1:0] CFG_ALARM    = 2'd2;

  // reported state codes
  localparam logic [3:0] CODE_IDLE    = 4'd0;
  localparam logic [3:0] CODE_ENTRY   = 4'd1;
  localparam logic [3:0] CODE_COOK    = 4'd2;
  localparam logic [3:0] CODE_PAUSE   = 4'd3;
  localparam logic [3:0] CODE_ALARM   = 4'd4;
  localparam logic [3:0] CODE_D_IDLE  = 4'd5;
  localparam logic [3:0] CODE_D_ENTRY = 4'd6;
  localparam logic [3:0] CODE_D_COOK  = 4'd7;
  localparam logic [3:0] CODE_D_PAUSE = 4'd8;

  // lamp bits
  localparam logic [2:0] LB_MAG   = 3'b001;
  localparam logic [2:0] LB_LIGHT = 3'b010;
  localparam logic [2:0] LB_ALARM = 3'b100;

  typedef enum logic [2:0] {
    EV_DIGIT = 3'd0,
    EV_START = 3'd1,
    EV_STOP  = 3'd2,
    EV_ADD   = 3'd3,
    EV_DOOR  = 3'd4,
    EV_TICK  = 3'd5,
    EV_NONE  = 3'd6
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [3:0] digit;
  } ev_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [NUM_DIGITS-1:0][3:0] digs_t;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_ENTRY   = 9'b000000010,
    ST_COOK    = 9'b000000100,
    ST_PAUSE   = 9'b000001000,
    ST_ALARM   = 9'b000010000,
    ST_D_IDLE  = 9'b000100000,
    ST_D_ENTRY = 9'b001000000,
    ST_D_COOK  = 9'b010000000,
    ST_D_PAUSE = 9'b100000000
  } state_t;

  function automatic logic [SEC_W-1:0] digits_sec(input digs_t d);
    logic [SEC_W-1:0] mm;
    logic [SEC_W-1:0] ss;
    mm = SEC_W'(d[0]) * TEN + SEC_W'(d[1]);
    ss = SEC_W'(d[2]) * TEN + SEC_W'(d[3]);
    return SEC_W'(mm * SIXTY + ss);
  endfunction

  function automatic logic [SEC_W-1:0] clamp_max(input logic [SEC_W-1:0] v,
                                                  input logic [SEC_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [3:0] state_code(input state_t s);
    logic [3:0] c;
    case (s)
      ST_IDLE:    c = CODE_IDLE;
      ST_ENTRY:   c = CODE_ENTRY;
      ST_COOK:    c = CODE_COOK;
      ST_PAUSE:   c = CODE_PAUSE;
      ST_ALARM:   c = CODE_ALARM;
      ST_D_IDLE:  c = CODE_D_IDLE;
      ST_D_ENTRY: c = CODE_D_ENTRY;
      ST_D_COOK:  c = CODE_D_COOK;
      ST_D_PAUSE: c = CODE_D_PAUSE;
      default:    c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- src/octc_front.sv -----
// Front stage: takes key and tick requests and classifies them into events.
// Depends on octc_pkg; feeds octc_queue.
`timescale 1ns / 1ps

module octc_front import octc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_mode,
  input  logic [3:0] in_digit,
  input  q_stat_t    q_stat,
  output logic       push,
  output ev_t        push_ev
);

  logic     fr_valid_r, fr_valid_nxt;
  ev_t      fr_ev_r;
  ev_kind_t kind;
  logic     accept;

  always_comb begin
    case (in_mode)
      MODE_DIGIT: kind = (in_digit > MAX_DIGIT) ? EV_NONE : EV_DIGIT;
      MODE_START: kind = EV_START;
      MODE_STOP:  kind = EV_STOP;
      MODE_ADD:   kind = EV_ADD;
      MODE_DOOR:  kind = EV_DOOR;
      MODE_TICK:  kind = EV_TICK;
      default:    kind = EV_NONE;
    endcase
  end

  assign in_stall = fr_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid_r && !q_stat.full;
  assign push_ev  = fr_ev_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_ev_r.kind  <= kind;
      fr_ev_r.digit <= in_digit;
    end
  end

endmodule

// ----- src/octc_queue.sv -----
// Short event queue between the front and back stages, head read directly.
// Depends on octc_pkg for the event type.
`timescale 1ns / 1ps

module octc_queue import octc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_D
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  ev_t     wr_ev,
  input  logic    rd_en,
  output ev_t     rd_ev,
  output q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);

  ev_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  assign stat.full  = (occ_r == OCC_W'(DEPTH));
  assign stat.empty = (occ_r == '0);
  assign rd_ev      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    occ_nxt    = occ_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      occ_nxt = occ_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_ev;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && stat.full))
    else $error("push into full event queue");

endmodule

// ----- src/octc_back.sv -----
// Back stage: runs the cook-timer state machine on queued events and holds
// the configuration and the result register. Depends on octc_pkg.
`timescale 1ns / 1ps

module octc_back import octc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  q_stat_t          q_stat,
  input  ev_t              head_ev,
  output logic             pop,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [SEC_W-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       out_state_code,
  output logic             out_magnetron_on,
  output logic             out_light_on,
  output logic             out_alarm_led,
  output logic [SEC_W-1:0] out_shown_seconds
);

  logic [ADD_W-1:0] add_step_r;
  logic [SEC_W-1:0] max_sec_r;
  logic [ALM_W-1:0] alarm_sec_r;

  state_t           st_r, st_nxt;
  digs_t            dig_r, dig_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SEC_W-1:0] rem_r, rem_nxt;
  logic [ALM_W-1:0] acnt_r, acnt_nxt;
  logic [2:0]       lamp_r, lamp_nxt;

  logic             ob_valid_r, ob_valid_nxt;
  logic [3:0]       ob_code_r;
  logic [2:0]       ob_lamp_r;
  logic [SEC_W-1:0] ob_shown_r;

  logic [SEC_W:0]   add_sum;
  logic [SEC_W-1:0] add_sat;
  logic [SEC_W-1:0] entry_sec;
  logic [ALM_W-1:0] acnt_inc;
  logic [SEC_W-1:0] shown;
  logic [3:0]       d;

  assign pop = !q_stat.empty && (!ob_valid_r || !out_stall);
  assign d   = head_ev.digit;

  assign add_sum   = {1'b0, rem_r} + (SEC_W + 1)'(add_step_r);
  assign add_sat   = (add_sum > {1'b0, max_sec_r}) ? max_sec_r : add_sum[SEC_W-1:0];
  assign entry_sec = clamp_max(digits_sec(dig_r), max_sec_r);
  assign acnt_inc  = (acnt_r < ALARM_SAT) ? acnt_r + 1'b1 : acnt_r;

  always_comb begin
    st_nxt   = st_r;
    dig_nxt  = dig_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    acnt_nxt = acnt_r;
    lamp_nxt = lamp_r;
    case (head_ev.kind)
      EV_DIGIT: begin
        if (st_r inside {ST_IDLE, ST_ENTRY, ST_D_IDLE, ST_D_ENTRY}) begin
          if (cnt_r < CNT_W'(NUM_DIGITS)) begin
            for (int i = 0; i < NUM_DIGITS - 1; i++) begin
              dig_nxt[i] = dig_r[i + 1];
            end
            dig_nxt[NUM_DIGITS - 1] = d;
            if (!(cnt_r == '0 && d == 4'd0)) begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          st_nxt = (st_r inside {ST_IDLE, ST_ENTRY}) ? ST_ENTRY : ST_D_ENTRY;
        end
      end
      EV_START: begin
        if (st_r == ST_ENTRY) begin
          rem_nxt = entry_sec;
          if (entry_sec != '0) begin
            lamp_nxt = LB_MAG | LB_LIGHT;
            st_nxt   = ST_COOK;
          end
        end else if (st_r == ST_PAUSE) begin
          lamp_nxt = lamp_r | LB_MAG | LB_LIGHT;
          st_nxt   = ST_COOK;
        end
      end
      EV_STOP: begin
        if (st_r inside {ST_ENTRY, ST_PAUSE, ST_ALARM}) begin
          dig_nxt  = '0;
          cnt_nxt  = '0;
          rem_nxt  = '0;
          lamp_nxt = '0;
          st_nxt   = ST_IDLE;
        end else if (st_r == ST_COOK) begin
          lamp_nxt = (lamp_r & ~LB_MAG) | LB_LIGHT;
          st_nxt   = ST_PAUSE;
        end else if (st_r inside {ST_D_ENTRY, ST_D_COOK, ST_D_PAUSE}) begin
          dig_nxt  = '0;
          cnt_nxt  = '0;
          rem_nxt  = '0;
          lamp_nxt = LB_LIGHT;
          st_nxt   = ST_D_IDLE;
        end
      end
      EV_ADD: begin
        if (st_r inside {ST_IDLE, ST_ENTRY, ST_COOK, ST_PAUSE}) begin
          rem_nxt  = add_sat;
          lamp_nxt = lamp_r | LB_MAG | LB_LIGHT;
          st_nxt   = ST_COOK;
        end
      end
      EV_DOOR: begin
        case (st_r)
          ST_IDLE, ST_ALARM: begin
            lamp_nxt = (lamp_r & ~LB_MAG) | LB_LIGHT;
            st_nxt   = ST_D_IDLE;
          end
          ST_ENTRY: begin
            lamp_nxt = (lamp_r & ~LB_MAG) | LB_LIGHT;
            st_nxt   = ST_D_ENTRY;
          end
          ST_COOK: begin
            lamp_nxt = (lamp_r & ~LB_MAG) | LB_LIGHT;
            st_nxt   = ST_D_COOK;
          end
          ST_PAUSE: begin
            lamp_nxt = (lamp_r & ~LB_MAG) | LB_LIGHT;
            st_nxt   = ST_D_PAUSE;
          end
          ST_D_IDLE: begin
            dig_nxt  = '0;
            cnt_nxt  = '0;
            rem_nxt  = '0;
            lamp_nxt = '0;
            st_nxt   = ST_IDLE;
          end
          ST_D_ENTRY: begin
            lamp_nxt = lamp_r & ~(LB_MAG | LB_LIGHT);
            st_nxt   = ST_ENTRY;
          end
          ST_D_COOK: begin
            lamp_nxt = lamp_r | LB_MAG | LB_LIGHT;
            st_nxt   = ST_COOK;
          end
          ST_D_PAUSE: begin
            lamp_nxt = (lamp_r & ~LB_MAG) | LB_LIGHT;
            st_nxt   = ST_PAUSE;
          end
          default: begin
            st_nxt = st_r;
          end
        endcase
      end
      EV_TICK: begin
        if (st_r == ST_COOK) begin
          if (rem_r != '0) begin
            rem_nxt = rem_r - 1'b1;
            if (rem_r == SEC_W'(1)) begin
              acnt_nxt = '0;
              lamp_nxt = LB_ALARM;
              st_nxt   = ST_ALARM;
            end
          end
        end else if (st_r == ST_ALARM) begin
          acnt_nxt = acnt_inc;
          lamp_nxt = lamp_r ^ LB_ALARM;
          if (acnt_inc >= alarm_sec_r) begin
            dig_nxt  = '0;
            cnt_nxt  = '0;
            rem_nxt  = '0;
            lamp_nxt = '0;
            st_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  always_comb begin
    if (st_nxt inside {ST_ENTRY, ST_D_ENTRY}) begin
      shown = clamp_max(digits_sec(dig_nxt), max_sec_r);
    end else if (st_nxt inside {ST_COOK, ST_PAUSE, ST_D_COOK, ST_D_PAUSE}) begin
      shown = rem_nxt;
    end else begin
      shown = '0;
    end
  end

  always_comb begin
    ob_valid_nxt = ob_valid_r;
    if (pop) begin
      ob_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      ob_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      dig_r       <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      acnt_r      <= '0;
      lamp_r      <= '0;
      ob_valid_r  <= 1'b0;
      add_step_r  <= ADD_STEP_RST;
      max_sec_r   <= MAX_SEC_RST;
      alarm_sec_r <= ALARM_RST;
    end else begin
      ob_valid_r <= ob_valid_nxt;
      if (pop) begin
        st_r   <= st_nxt;
        dig_r  <= dig_nxt;
        cnt_r  <= cnt_nxt;
        rem_r  <= rem_nxt;
        acnt_r <= acnt_nxt;
        lamp_r <= lamp_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ADD_STEP: add_step_r  <= cfg_data[ADD_W-1:0];
          CFG_MAX_SEC:  max_sec_r   <= cfg_data;
          CFG_ALARM:    alarm_sec_r <= cfg_data[ALM_W-1:0];
          default:      add_step_r  <= add_step_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ob_code_r  <= state_code(st_nxt);
      ob_lamp_r  <= lamp_nxt;
      ob_shown_r <= shown;
    end
  end

  assign out_valid         = ob_valid_r;
  assign out_state_code    = ob_code_r;
  assign out_magnetron_on  = ob_lamp_r[0];
  assign out_light_on      = ob_lamp_r[1];
  assign out_alarm_led     = ob_lamp_r[2];
  assign out_shown_seconds = ob_shown_r;

  a_mag_only_cook: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_valid_r && ob_lamp_r[0]) |-> (ob_code_r == CODE_COOK))
    else $error("magnetron driven outside cook state");

  a_blank_display: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_valid_r && (ob_code_r == CODE_IDLE || ob_code_r == CODE_ALARM ||
                    ob_code_r == CODE_D_IDLE)) |-> (ob_shown_r == '0))
    else $error("nonzero display in idle or alarm state");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> ob_valid_r)
    else $error("executed event produced no result");

endmodule

// ----- src/oven_cook_timer_controller.sv -----
// Oven cook-timer controller: front classifier, event queue, state machine.
// Each request passes the front register, the event queue and then the result register.
// Throughput: one request and one retired event per cycle while out_stall is low.
// A stalled output fills the queue, then the front register, then raises in_stall.
// Reset (rst_n low, synchronous): idle state, digits and timers cleared, lamps off,
// configuration back to defaults; no clearing pass, ready the cycle after reset.
`timescale 1ns / 1ps

module oven_cook_timer_controller import octc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_mode,
  input  logic [3:0]       in_digit,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       out_state_code,
  output logic             out_magnetron_on,
  output logic             out_light_on,
  output logic             out_alarm_led,
  output logic [SEC_W-1:0] out_shown_seconds,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [SEC_W-1:0] cfg_data
);

  q_stat_t q_stat;
  logic    push;
  ev_t     push_ev;
  logic    pop;
  ev_t     head_ev;

  assign cfg_ready = 1'b1;

  octc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_digit (in_digit),
    .q_stat   (q_stat),
    .push     (push),
    .push_ev  (push_ev)
  );

  octc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (push),
    .wr_ev (push_ev),
    .rd_en (pop),
    .rd_ev (head_ev),
    .stat  (q_stat)
  );

  octc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .head_ev           (head_ev),
    .pop               (pop),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_state_code    (out_state_code),
    .out_magnetron_on  (out_magnetron_on),
    .out_light_on      (out_light_on),
    .out_alarm_led     (out_alarm_led),
    .out_shown_seconds (out_shown_seconds)
  );

endmodule

// ----- tb/tb_oven_cook_timer_controller.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the oven cook-timer controller: directed and random key and tick
// requests under varying idle and stall pressure, with a predicting scoreboard class.
// Depends on octc_pkg and the oven_cook_timer_controller RTL.

module tb_oven_cook_timer_controller;
  import octc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int SEG_ITEMS      = 140;
  localparam int NUM_SEGS       = 8;
  localparam int MAX_REPORTS    = 10;

  localparam logic [2:0] MODE_NONE = 3'(EV_NONE);
  localparam logic [2:0] MODE_RSVD = 3'd7;

  typedef struct packed {
    logic [3:0]       code;
    logic             mag;
    logic             light;
    logic             alarm;
    logic [SEC_W-1:0] shown;
  } oven_view_t;

  class cook_timer_scoreboard;
    logic [ADD_W-1:0] add_step;
    logic [SEC_W-1:0] max_sec;
    logic [ALM_W-1:0] alarm_sec;
    logic [3:0]       code;
    logic [3:0]       digs[NUM_DIGITS];
    int               dig_cnt;
    logic [SEC_W-1:0] remaining;
    logic [ALM_W-1:0] alarm_cnt;
    logic [2:0]       lamps;
    oven_view_t       expected_views[$];
    int               mismatches;

    function new();
      add_step   = ADD_STEP_RST;
      max_sec    = MAX_SEC_RST;
      alarm_sec  = ALARM_RST;
      code       = CODE_IDLE;
      alarm_cnt  = '0;
      mismatches = 0;
      clear_entry(3'b000);
    endfunction

    function void clear_entry(input logic [2:0] lamp_val);
      for (int i = 0; i < NUM_DIGITS; i++) digs[i] = 4'd0;
      dig_cnt   = 0;
      remaining = '0;
      lamps     = lamp_val;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [SEC_W-1:0] data);
      case (idx)
        CFG_ADD_STEP: add_step  = data[ADD_W-1:0];
        CFG_MAX_SEC:  max_sec   = data;
        CFG_ALARM:    alarm_sec = data[ALM_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [SEC_W-1:0] entered_clamped();
      int v;
      v = (digs[0] * 10 + digs[1]) * 60 + digs[2] * 10 + digs[3];
      if (v > max_sec) v = max_sec;
      return SEC_W'(v);
    endfunction

    function void shift_digit(input logic [3:0] d);
      if (dig_cnt < NUM_DIGITS) begin
        for (int i = 0; i < NUM_DIGITS - 1; i++) digs[i] = digs[i+1];
        digs[NUM_DIGITS-1] = d;
        if (!(dig_cnt == 0 && d == 4'd0)) dig_cnt++;
      end
    endfunction

    function void pause_lamps();
      lamps = (lamps & ~LB_MAG) | LB_LIGHT;
    endfunction

    function void note_request(input logic [2:0] mode, input logic [3:0] digit);
      oven_view_t v;
      int sum;
      case (mode)
        MODE_DIGIT: begin
          if (digit <= MAX_DIGIT) begin
            if (code == CODE_IDLE || code == CODE_ENTRY) begin
              shift_digit(digit);
              code = CODE_ENTRY;
            end else if (code == CODE_D_IDLE || code == CODE_D_ENTRY) begin
              shift_digit(digit);
              code = CODE_D_ENTRY;
            end
          end
        end
        MODE_START: begin
          if (code == CODE_ENTRY) begin
            remaining = entered_clamped();
            if (remaining != 0) begin
              lamps = LB_MAG | LB_LIGHT;
              code  = CODE_COOK;
            end
          end else if (code == CODE_PAUSE) begin
            lamps = lamps | LB_MAG | LB_LIGHT;
            code  = CODE_COOK;
          end
        end
        MODE_STOP: begin
          case (code)
            CODE_ENTRY, CODE_PAUSE, CODE_ALARM: begin
              clear_entry(3'b000);
              code = CODE_IDLE;
            end
            CODE_COOK: begin
              pause_lamps();
              code = CODE_PAUSE;
            end
            CODE_D_ENTRY, CODE_D_COOK, CODE_D_PAUSE: begin
              clear_entry(LB_LIGHT);
              code = CODE_D_IDLE;
            end
            default: ;
          endcase
        end
        MODE_ADD: begin
          if (code == CODE_IDLE || code == CODE_ENTRY || code == CODE_COOK ||
              code == CODE_PAUSE) begin
            sum = remaining + add_step;
            if (sum > max_sec) sum = max_sec;
            remaining = SEC_W'(sum);
            lamps = lamps | LB_MAG | LB_LIGHT;
            code  = CODE_COOK;
          end
        end
        MODE_DOOR: begin
          case (code)
            CODE_IDLE, CODE_ALARM: begin
              pause_lamps();
              code = CODE_D_IDLE;
            end
            CODE_ENTRY: begin
              pause_lamps();
              code = CODE_D_ENTRY;
            end
            CODE_COOK: begin
              pause_lamps();
              code = CODE_D_COOK;
            end
            CODE_PAUSE: begin
              pause_lamps();
              code = CODE_D_PAUSE;
            end
            CODE_D_IDLE: begin
              clear_entry(3'b000);
              code = CODE_IDLE;
            end
            CODE_D_ENTRY: begin
              lamps = lamps & ~(LB_MAG | LB_LIGHT);
              code  = CODE_ENTRY;
            end
            CODE_D_COOK: begin
              lamps = lamps | LB_MAG | LB_LIGHT;
              code  = CODE_COOK;
            end
            CODE_D_PAUSE: begin
              pause_lamps();
              code = CODE_PAUSE;
            end
            default: ;
          endcase
        end
        MODE_TICK: begin
          if (code == CODE_COOK) begin
            if (remaining > 0) begin
              remaining = remaining - 1'b1;
              if (remaining == 0) begin
                alarm_cnt = '0;
                lamps     = LB_ALARM;
                code      = CODE_ALARM;
              end
            end
          end else if (code == CODE_ALARM) begin
            if (alarm_cnt < ALARM_SAT) alarm_cnt = alarm_cnt + 1'b1;
            lamps = lamps ^ LB_ALARM;
            if (alarm_cnt >= alarm_sec) begin
              clear_entry(3'b000);
              code = CODE_IDLE;
            end
          end
        end
        default: ;
      endcase

      v.code  = code;
      v.mag   = lamps[0];
      v.light = lamps[1];
      v.alarm = lamps[2];
      case (code)
        CODE_ENTRY, CODE_D_ENTRY: v.shown = entered_clamped();
        CODE_COOK, CODE_PAUSE, CODE_D_COOK, CODE_D_PAUSE: v.shown = remaining;
        default: v.shown = '0;
      endcase
      expected_views.push_back(v);
    endfunction

    function void check_result(input oven_view_t got);
      oven_view_t want;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request pending: state %0d shown %0d",
                   $time, got.code, got.shown);
        return;
      end
      want = expected_views.pop_front();
      if (got.code !== want.code || got.mag !== want.mag || got.light !== want.light ||
          got.alarm !== want.alarm || got.shown !== want.shown) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: mismatch exp state %0d mag %0b light %0b alarm %0b shown %0d,",
                    " got state %0d mag %0b light %0b alarm %0b shown %0d"},
                   $time, want.code, want.mag, want.light, want.alarm, want.shown,
                   got.code, got.mag, got.light, got.alarm, got.shown);
      end
    endfunction

    function int pending();
      return expected_views.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       in_mode = '0;
  logic [3:0]       in_digit = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [3:0]       out_state_code;
  logic             out_magnetron_on;
  logic             out_light_on;
  logic             out_alarm_led;
  logic [SEC_W-1:0] out_shown_seconds;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [SEC_W-1:0] cfg_data = '0;

  cook_timer_scoreboard sb;
  oven_view_t           seen_view;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   sent_total = 0;
  int                   quiet_cycles = 0;

  oven_cook_timer_controller DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_digit          (in_digit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_state_code    (out_state_code),
    .out_magnetron_on  (out_magnetron_on),
    .out_light_on      (out_light_on),
    .out_alarm_led     (out_alarm_led),
    .out_shown_seconds (out_shown_seconds),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_view.code  = out_state_code;
      seen_view.mag   = out_magnetron_on;
      seen_view.light = out_light_on;
      seen_view.alarm = out_alarm_led;
      seen_view.shown = out_shown_seconds;
      sb.check_result(seen_view);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [2:0] mode, input logic [3:0] digit);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_digit <= digit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(mode, digit);
    sent_total++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [SEC_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic write_settings(input int add_step, input int max_sec, input int alarm_sec);
    write_reg(CFG_ADD_STEP, SEC_W'(add_step));
    write_reg(CFG_MAX_SEC, SEC_W'(max_sec));
    write_reg(CFG_ALARM, SEC_W'(alarm_sec));
    cfg_valid <= 1'b0;
  endtask

  task automatic go_idle();
    int guard;
    guard = 0;
    while (sb.code != CODE_IDLE && guard < 8) begin
      case (sb.code)
        CODE_D_IDLE, CODE_D_ENTRY, CODE_D_COOK, CODE_D_PAUSE: send_request(MODE_DOOR, '0);
        default: send_request(MODE_STOP, 4'($urandom_range(15)));
      endcase
      guard++;
    end
  endtask

  task automatic send_random_event();
    int r;
    r = $urandom_range(5);
    case (r)
      0: send_request(MODE_STOP, '0);
      1: send_request(MODE_DOOR, '0);
      2: send_request(MODE_ADD, '0);
      3: send_request(MODE_START, '0);
      4: send_request(MODE_DIGIT, 4'($urandom_range(15)));
      default: send_request(3'($urandom_range(7)), 4'($urandom_range(15)));
    endcase
  endtask

  // enter a short time, start it or add time, then mostly tick through cooking and the alarm
  task automatic cook_sequence();
    int n;
    int cap;
    int r;
    logic [3:0] d;
    go_idle();
    n = $urandom_range(1, NUM_DIGITS);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1 || $urandom_range(3) == 0) d = 4'($urandom_range(9));
      else d = 4'd0;
      send_request(MODE_DIGIT, d);
    end
    if ($urandom_range(99) < 15) send_request(MODE_ADD, '0);
    else send_request(MODE_START, '0);
    cap = $urandom_range(10, 60);
    for (int k = 0; k < cap && sb.code != CODE_IDLE; k++) begin
      r = $urandom_range(99);
      case (sb.code)
        CODE_COOK: begin
          if (r < 78) send_request(MODE_TICK, 4'($urandom_range(15)));
          else send_random_event();
        end
        CODE_PAUSE: begin
          if (r < 50) send_request(MODE_START, '0);
          else if (r < 70) send_request(MODE_TICK, '0);
          else if (r < 85) send_request(MODE_DOOR, '0);
          else send_random_event();
        end
        CODE_ALARM: begin
          if (r < 85) send_request(MODE_TICK, '0);
          else if (r < 93) send_request(MODE_DOOR, '0);
          else send_random_event();
        end
        CODE_ENTRY: begin
          if (r < 60) send_request(MODE_START, '0);
          else if (r < 80) send_request(MODE_DIGIT, 4'($urandom_range(9)));
          else send_random_event();
        end
        default: begin
          if (r < 60) send_request(MODE_DOOR, '0);
          else if (r < 75) send_request(MODE_TICK, '0);
          else send_random_event();
        end
      endcase
    end
  endtask

  task automatic set_phase(input int sel);
    case (sel)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 86; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 86; end
      default: begin idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  task automatic apply_segment_settings(input int seg);
    case (seg)
      0: write_settings(30, 3599, 5);
      1: write_settings(1, 1, 1);
      2: write_settings(3599, 5999, 15);
      4: write_settings(7, 20, 3);
      7: write_settings(1, 5999, 15);
      default: begin
        if ($urandom_range(3) == 0) write_settings($urandom_range(1, 3599),
                                                   $urandom_range(1, 5999),
                                                   $urandom_range(1, 15));
        else write_settings($urandom_range(1, 60), $urandom_range(1, 5999),
                            $urandom_range(1, 15));
      end
    endcase
  endtask

  initial begin
    int goal;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_phase(0);
    send_request(MODE_DIGIT, 4'd0);
    repeat (4) send_request(MODE_DIGIT, 4'd9);
    send_request(MODE_DIGIT, 4'd5);
    send_request(MODE_DIGIT, 4'd15);
    send_request(MODE_NONE, 4'd3);
    send_request(MODE_RSVD, 4'd12);
    send_request(MODE_START, '0);
    send_request(MODE_ADD, '0);
    send_request(MODE_TICK, '0);
    send_request(MODE_STOP, '0);
    send_request(MODE_DOOR, '0);
    send_request(MODE_STOP, '0);
    send_request(MODE_DOOR, '0);
    send_request(MODE_DIGIT, 4'd0);
    send_request(MODE_START, '0);
    send_request(MODE_STOP, '0);
    send_request(MODE_DIGIT, 4'd1);
    send_request(MODE_START, '0);
    send_request(MODE_TICK, '0);
    send_request(MODE_DOOR, '0);
    send_request(MODE_DOOR, '0);
    send_request(MODE_TICK, 4'd15);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain_results();
      apply_segment_settings(seg);
      set_phase(seg % 4);
      goal = sent_total + SEG_ITEMS;
      while (sent_total < goal) begin
        if ($urandom_range(99) < 20) send_request(3'($urandom_range(7)), 4'($urandom_range(15)));
        else cook_sequence();
      end
    end

    drain_results();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
